// File: hw/rtl/cbd_pkg.sv
// package for the console cpu bus decoder
// route codes, memory map constants and the decode result struct
// no dependencies
`timescale 1ns / 1ps

package cbd_pkg;

  localparam int unsigned RAM_BYTES_DEF = 2048;

  // address window bounds, register addresses, the ppu mirror mask and the pad open-bus value
  localparam logic [15:0] RAM_TOP  = 16'h1FFF;
  localparam logic [15:0] PPU_TOP  = 16'h3FFF;
  localparam logic [15:0] IO_TOP   = 16'h40FF;
  localparam logic [15:0] APU_TOP  = 16'h4013;
  localparam logic [15:0] DMA_ADDR = 16'h4014;
  localparam logic [15:0] APU_STAT = 16'h4015;
  localparam logic [15:0] PAD_ADDR = 16'h4016;
  localparam logic [15:0] APU_FRM  = 16'h4017;
  localparam logic [15:0] PPU_MASK = 16'h0007;
  localparam logic [7:0]  PAD_OPEN = 8'h40;

  // reciprocal shift for the ram mirror reduction
  localparam int unsigned DIV_SHIFT = 26;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ROUTE_RAM  = 3'd0,
    ROUTE_PPU  = 3'd1,
    ROUTE_APU  = 3'd2,
    ROUTE_DMA  = 3'd3,
    ROUTE_PAD  = 3'd4,
    ROUTE_CART = 3'd5,
    ROUTE_NONE = 3'd6
  } route_t;

  typedef struct packed {
    route_t      route;
    logic [15:0] raddr;
    logic [7:0]  rdat;
    logic        ram_rd;
    logic        ram_wr;
    logic        pad_wr;
    logic        pad_rd;
  } dec_t;

endpackage

// File: hw/rtl/cbd_decode.sv
// address decoder of the console memory map
// depends on cbd_pkg for route codes, window bounds and dec_t
`timescale 1ns / 1ps

module cbd_decode (
  input  logic              command,
  input  logic [15:0]       address,
  input  logic [7:0]        write_data,
  output cbd_pkg::dec_t     dec
);

  logic wr;

  assign wr = (command == cbd_pkg::CMD_WRITE);

  always_comb begin
    dec.route  = cbd_pkg::ROUTE_NONE;
    dec.raddr  = address;
    dec.rdat   = wr ? write_data : 8'd0;
    dec.ram_rd = 1'b0;
    dec.ram_wr = 1'b0;
    dec.pad_wr = 1'b0;
    dec.pad_rd = 1'b0;
    if (address <= cbd_pkg::RAM_TOP) begin
      dec.route  = cbd_pkg::ROUTE_RAM;
      dec.ram_wr = wr;
      dec.ram_rd = !wr;
    end else if (address <= cbd_pkg::PPU_TOP) begin
      dec.route = cbd_pkg::ROUTE_PPU;
      dec.raddr = address & cbd_pkg::PPU_MASK;
    end else if (address <= cbd_pkg::IO_TOP) begin
      if (wr) begin
        if (address == cbd_pkg::DMA_ADDR) begin
          dec.route = cbd_pkg::ROUTE_DMA;
        end else if (address <= cbd_pkg::APU_TOP || address == cbd_pkg::APU_STAT ||
                     address == cbd_pkg::APU_FRM) begin
          dec.route = cbd_pkg::ROUTE_APU;
        end else if (address == cbd_pkg::PAD_ADDR) begin
          dec.route  = cbd_pkg::ROUTE_PAD;
          dec.pad_wr = 1'b1;
        end
      end else if (address == cbd_pkg::PAD_ADDR) begin
        dec.route  = cbd_pkg::ROUTE_PAD;
        dec.pad_rd = 1'b1;
      end
    end else begin
      dec.route = cbd_pkg::ROUTE_CART;
    end
  end

endmodule

// File: hw/rtl/console_cpu_bus_decoder_core.sv
// top level of the console cpu bus decoder: work ram, controller port, pipeline
// depends on cbd_pkg and cbd_decode
`timescale 1ns / 1ps

// One CPU bus access goes in per item and one routing result comes out per item,
// in order. The block sustains one item per clock while the output is not stalled;
// an item passes three register stages: an input stage that reduces the ram mirror
// address, the single-port work ram access (read data registered) with the
// controller latch update, and the output register. After reset the work ram is
// cleared one byte a cycle while s_axis_tready is low.
module console_cpu_bus_decoder_core #(
  parameter int unsigned RAM_BYTES = cbd_pkg::RAM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address[15:0], write_data[23:16], buttons[31:24]
  input  logic [0:0]  s_axis_tuser,   // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_data[7:0], route_address[23:8], route_data[31:24]
  output logic [2:0]  m_axis_tuser    // route[2:0]
);

  localparam int unsigned IdxW  = $clog2(RAM_BYTES);
  localparam logic [31:0] Recip = 32'((64'd1 << cbd_pkg::DIV_SHIFT) / RAM_BYTES);
  localparam logic [13:0] NBytes = 14'(RAM_BYTES);

  logic [7:0] work_ram [RAM_BYTES];

  // clearing pass
  logic            clearing;
  logic [IdxW-1:0] clr_addr;

  // stage a
  logic          a_valid;
  logic          a_cmd;
  logic [15:0]   a_addr;
  logic [7:0]    a_wdata;
  logic [7:0]    a_btn;
  logic [5:0]    a_q;
  cbd_pkg::dec_t a_dec;
  logic [13:0]   a_qn;
  logic [13:0]   a_rem0;
  logic [13:0]   a_rem1;
  logic [IdxW-1:0] a_idx;
  logic [31:0]   in_prod;

  // stage b
  logic           b_valid;
  cbd_pkg::route_t b_route;
  logic [15:0]    b_raddr;
  logic [7:0]     b_rdat;
  logic           b_ram_rd;
  logic           b_pad_rd;
  logic [7:0]     b_pad_data;
  logic [7:0]     ram_q;
  logic [7:0]     b_rdata;

  // output register
  logic           o_valid;
  logic [7:0]     o_rdata;
  cbd_pkg::route_t o_route;
  logic [15:0]    o_raddr;
  logic [7:0]     o_rdat;

  // controller port
  logic [7:0] pad_shift;
  logic       pad_strobe;

  logic o_free, b_free, a_free, b_adv, a_adv, in_acc;

  assign o_free = !o_valid || m_axis_tready;
  assign b_adv  = b_valid && o_free;
  assign b_free = !b_valid || o_free;
  assign a_adv  = a_valid && b_free;
  assign a_free = !a_valid || b_free;
  assign s_axis_tready = a_free && !clearing;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign in_prod = {19'd0, s_axis_tdata[12:0]} * Recip;

  cbd_decode u_dec (
    .command    (a_cmd),
    .address    (a_addr),
    .write_data (a_wdata),
    .dec        (a_dec)
  );

  // mirror reduction: address mod RAM_BYTES, quotient estimate is exact or one low
  assign a_qn   = 14'(a_q * NBytes);
  assign a_rem0 = {1'b0, a_addr[12:0]} - a_qn;
  assign a_rem1 = (a_rem0 >= NBytes) ? (a_rem0 - NBytes) : a_rem0;
  assign a_idx  = a_rem1[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IdxW'(RAM_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      work_ram[clr_addr] <= 8'd0;
    end else if (a_adv && a_dec.ram_wr) begin
      work_ram[a_idx] <= a_wdata;
    end
    if (a_adv && a_dec.ram_rd) begin
      ram_q <= work_ram[a_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= in_acc;
    end
    if (in_acc) begin
      a_cmd   <= s_axis_tuser[0];
      a_addr  <= s_axis_tdata[15:0];
      a_wdata <= s_axis_tdata[23:16];
      a_btn   <= s_axis_tdata[31:24];
      a_q     <= in_prod[31:26];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_shift  <= 8'd0;
      pad_strobe <= 1'b0;
    end else if (a_adv) begin
      if (a_dec.pad_wr) begin
        pad_strobe <= a_wdata[0];
        if (a_wdata[0]) begin
          pad_shift <= a_btn;
        end
      end else if (a_dec.pad_rd && !pad_strobe) begin
        pad_shift <= {1'b0, pad_shift[7:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_adv;
    end
    if (a_adv) begin
      b_route    <= a_dec.route;
      b_raddr    <= a_dec.raddr;
      b_rdat     <= a_dec.rdat;
      b_ram_rd   <= a_dec.ram_rd;
      b_pad_rd   <= a_dec.pad_rd;
      b_pad_data <= cbd_pkg::PAD_OPEN | {7'd0, pad_shift[0]};
    end
  end

  always_comb begin
    b_rdata = 8'd0;
    if (b_ram_rd) begin
      b_rdata = ram_q;
    end else if (b_pad_rd) begin
      b_rdata = b_pad_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= b_adv;
    end
    if (b_adv) begin
      o_rdata <= b_rdata;
      o_route <= b_route;
      o_raddr <= b_raddr;
      o_rdat  <= b_rdat;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {o_rdat, o_raddr, o_rdata};
  assign m_axis_tuser  = o_route;

endmodule
